FILE: rtl/core/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define IDC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define IDC_ASSERT(lbl, prop, msg)
`define IDC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/idc_pkg.sv
package idc_pkg;

    localparam int unsigned AxisW     = 16;
    localparam int unsigned StampW    = 32;
    localparam int unsigned SumW      = 32;
    localparam int unsigned MagW      = 16;
    localparam int unsigned GravW     = 13;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned InTdataW  = 88;
    localparam int unsigned OutTdataW = 24;
    localparam int unsigned QueueDepth = 2;

    localparam logic [CfgIdxW-1:0] CfgJerkLimit  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgAccelLimit = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgWindowMs   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgGravity    = 3'd3;

    localparam logic [1:0] OutcomeNone      = 2'd0;
    localparam logic [1:0] OutcomeCancelled = 2'd1;
    localparam logic [1:0] OutcomeSent      = 2'd2;
    localparam logic [1:0] OutcomeMissed    = 2'd3;

    localparam logic [15:0]      JerkLimitRst  = 16'd10240;
    localparam logic [15:0]      AccelLimitRst = 16'd10240;
    localparam logic [15:0]      WindowMsRst   = 16'd3000;
    localparam logic [GravW-1:0] GravityRst    = 13'd2509;

    localparam logic [9:0] MsPerSec = 10'd1000;

    typedef struct packed {
        logic [15:0]      jerk_limit;
        logic [15:0]      accel_limit;
        logic [15:0]      window_ms;
        logic [GravW-1:0] gravity_offset;
    } t_cfg;

    typedef struct packed {
        logic [SumW-1:0]   sum;
        logic [StampW-1:0] dt;
        logic [StampW-1:0] stamp;
        logic              button;
        logic              link;
    } t_item;

    typedef struct packed {
        logic [MagW-1:0] magnitude;
        logic [1:0]      outcome;
        logic            impact_now;
        logic            alert_on;
    } t_result;

endpackage

FILE: rtl/core/idc_fifo.sv
module idc_fifo #(
    parameter int unsigned DEPTH = idc_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  idc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output idc_pkg::t_item o_item
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    idc_pkg::t_item  r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            w_push, w_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: rtl/core/idc_front.sv
module idc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [idc_pkg::AxisW-1:0]    i_accel_x,
    input  logic signed [idc_pkg::AxisW-1:0]    i_accel_y,
    input  logic signed [idc_pkg::AxisW-1:0]    i_accel_z,
    input  logic [idc_pkg::StampW-1:0]          i_stamp_ms,
    input  logic                                i_button_pressed,
    input  logic                                i_link_connected,
    input  logic [idc_pkg::GravW-1:0]           i_gravity_offset,
    output logic                                o_push,
    output idc_pkg::t_item                      o_item,
    input  logic                                i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SQ   = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    localparam logic [1:0] SqLast = 2'd2;

    t_fstate                           r_state, n_state;
    logic [idc_pkg::StampW-1:0]        r_prev_stamp, n_prev_stamp;
    logic [1:0]                        r_cnt, n_cnt;
    logic signed [idc_pkg::AxisW:0]    r_x, r_y, r_z;
    logic [idc_pkg::StampW-1:0]        r_stamp, r_dt;
    logic                              r_button, r_link;
    logic [idc_pkg::SumW-1:0]          r_sum;

    logic                              w_take;
    logic signed [idc_pkg::AxisW:0]    w_z, w_op;
    logic signed [2*idc_pkg::AxisW+1:0] w_prod;

    assign o_ready = (r_state == F_IDLE);
    assign w_take  = o_ready && i_valid && (i_stamp_ms != r_prev_stamp);
    assign w_z     = {i_accel_z[idc_pkg::AxisW-1], i_accel_z}
                   - {4'b0000, i_gravity_offset};

    always_comb begin
        unique case (r_cnt)
            2'd0:    w_op = r_x;
            2'd1:    w_op = r_y;
            default: w_op = r_z;
        endcase
    end

    assign w_prod = w_op * w_op;

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_item = '{sum: r_sum, dt: r_dt, stamp: r_stamp, button: r_button, link: r_link};

    always_comb begin
        n_state      = r_state;
        n_prev_stamp = r_prev_stamp;
        n_cnt        = r_cnt;
        unique case (r_state)
            F_IDLE: begin
                if (w_take) begin
                    n_prev_stamp = i_stamp_ms;
                    n_cnt        = '0;
                    n_state      = F_SQ;
                end
            end
            F_SQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SqLast) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_prev_stamp <= '0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_prev_stamp <= n_prev_stamp;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_x      <= {i_accel_x[idc_pkg::AxisW-1], i_accel_x};
            r_y      <= {i_accel_y[idc_pkg::AxisW-1], i_accel_y};
            r_z      <= w_z;
            r_stamp  <= i_stamp_ms;
            r_dt     <= i_stamp_ms - r_prev_stamp;
            r_button <= i_button_pressed;
            r_link   <= i_link_connected;
            r_sum    <= '0;
        end else if (r_state == F_SQ) begin
            r_sum <= r_sum + w_prod[idc_pkg::SumW-1:0];
        end
    end

endmodule

FILE: rtl/core/idc_back.sv
module idc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  idc_pkg::t_item   i_item,
    input  idc_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    input  logic             i_ready,
    output idc_pkg::t_result o_result
);

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_ROOT   = 5'b00010,
        B_LHS    = 5'b00100,
        B_RHS    = 5'b01000,
        B_DECIDE = 5'b10000
    } t_bstate;

    localparam int unsigned MagW = idc_pkg::MagW;
    localparam logic [3:0]  RootLast = 4'd15;

    t_bstate                    r_state, n_state;
    logic [3:0]                 r_step;
    logic [idc_pkg::SumW-1:0]   r_val;
    logic [MagW:0]              r_rem;
    logic [MagW-1:0]            r_root;
    logic [idc_pkg::StampW-1:0] r_dt, r_stamp;
    logic                       r_button, r_link;
    logic [MagW+9:0]            r_lhs;
    logic [MagW+idc_pkg::StampW-1:0] r_rhs;

    logic                       r_alerting, r_button_seen;
    logic [idc_pkg::StampW-1:0] r_impact_stamp;
    logic [MagW-1:0]            r_prev_mag;
    logic                       r_out_valid;
    idc_pkg::t_result           r_out;

    logic [MagW+2:0]            w_rem_sh, w_trial, w_rem_sub;
    logic [MagW-1:0]            w_diff;
    logic                       w_out_free, w_jerk_high, w_impact;
    logic                       w_alert_a, w_seen_a, w_alert_b;
    logic [idc_pkg::StampW-1:0] w_istamp, w_elapsed;
    logic [1:0]                 w_outcome;

    assign o_valid    = r_out_valid;
    assign o_result   = r_out;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = (r_state == B_IDLE) && i_valid;

    // one result bit per step, restoring form
    assign w_rem_sh  = {r_rem, r_val[idc_pkg::SumW-1 -: 2]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_rem_sub = w_rem_sh - w_trial;
    assign w_diff   = (r_root >= r_prev_mag) ? r_root - r_prev_mag : r_prev_mag - r_root;

    assign w_jerk_high = {{(idc_pkg::StampW-10){1'b0}}, r_lhs} > r_rhs;
    assign w_impact    = w_jerk_high && (r_root > i_cfg.accel_limit) && !r_alerting;
    assign w_alert_a   = r_alerting || w_impact;
    assign w_istamp    = w_impact ? r_stamp : r_impact_stamp;
    assign w_seen_a    = (w_impact ? 1'b0 : r_button_seen) || (w_alert_a && r_button);
    assign w_elapsed   = r_stamp - w_istamp;

    always_comb begin
        w_alert_b = w_alert_a;
        w_outcome = idc_pkg::OutcomeNone;
        if (w_alert_a && (w_elapsed >= {16'd0, i_cfg.window_ms})) begin
            w_alert_b = 1'b0;
            priority if (w_seen_a) begin
                w_outcome = idc_pkg::OutcomeCancelled;
            end else if (r_link) begin
                w_outcome = idc_pkg::OutcomeSent;
            end else begin
                w_outcome = idc_pkg::OutcomeMissed;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:   if (i_valid) n_state = B_ROOT;
            B_ROOT:   if (r_step == RootLast) n_state = B_LHS;
            B_LHS:    n_state = B_RHS;
            B_RHS:    n_state = B_DECIDE;
            B_DECIDE: if (w_out_free) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= B_IDLE;
            r_alerting     <= 1'b0;
            r_button_seen  <= 1'b0;
            r_impact_stamp <= '0;
            r_prev_mag     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == B_DECIDE) && w_out_free) begin
                r_alerting     <= w_alert_b;
                r_button_seen  <= w_seen_a;
                r_impact_stamp <= w_istamp;
                r_prev_mag     <= r_root;
                r_out_valid    <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_val    <= i_item.sum;
                r_dt     <= i_item.dt;
                r_stamp  <= i_item.stamp;
                r_button <= i_item.button;
                r_link   <= i_item.link;
                r_rem    <= '0;
                r_root   <= '0;
                r_step   <= '0;
            end
            B_ROOT: begin
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sub[MagW:0];
                    r_root <= {r_root[MagW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh[MagW:0];
                    r_root <= {r_root[MagW-2:0], 1'b0};
                end
                r_val  <= {r_val[idc_pkg::SumW-3:0], 2'b00};
                r_step <= r_step + 1'b1;
            end
            B_LHS:    r_lhs <= w_diff * idc_pkg::MsPerSec;
            B_RHS:    r_rhs <= i_cfg.jerk_limit * r_dt;
            B_DECIDE: begin
                if (w_out_free) begin
                    r_out <= '{magnitude: r_root, outcome: w_outcome,
                               impact_now: w_impact, alert_on: w_alert_b};
                end
            end
            default: r_step <= '0;
        endcase
    end

endmodule

FILE: rtl/core/impact_detect_with_cancel_window.sv
// Impact detector with a user cancel window. Each accepted word is one accelerometer
// sample; a sample whose stamp equals the previous one is dropped without a result,
// every other sample gives exactly one result word. The front part takes a sample,
// squares the three axes on one multiplier and queues the sum; the back part runs
// the bit-serial square root, then the jerk products and the alert decision. The
// queue lets the front part take a new sample while the back part still works on
// the last one, until the queue is full. Configuration words are taken at once.
`include "assert_macros.svh"

module impact_detect_with_cancel_window #(
    parameter int unsigned QUEUE_DEPTH = idc_pkg::QueueDepth
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // accel_x[15:0] accel_y[31:16] accel_z[47:32] stamp_ms[79:48]
    // button_pressed[80] link_connected[81] zero[87:82]
    input  logic [idc_pkg::InTdataW-1:0]      i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // alert_on[0] impact_now[1] outcome[3:2] magnitude[19:4] zero[23:20]
    output logic [idc_pkg::OutTdataW-1:0]     o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [idc_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [idc_pkg::CfgDataW-1:0]      i_cfg_data
);

    idc_pkg::t_cfg    r_cfg;
    idc_pkg::t_item   w_front_item, w_queue_item;
    idc_pkg::t_result w_result;
    logic             w_push, w_full, w_queue_valid, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jerk_limit     <= idc_pkg::JerkLimitRst;
            r_cfg.accel_limit    <= idc_pkg::AccelLimitRst;
            r_cfg.window_ms      <= idc_pkg::WindowMsRst;
            r_cfg.gravity_offset <= idc_pkg::GravityRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                idc_pkg::CfgJerkLimit:  r_cfg.jerk_limit  <= i_cfg_data;
                idc_pkg::CfgAccelLimit: r_cfg.accel_limit <= i_cfg_data;
                idc_pkg::CfgWindowMs:   r_cfg.window_ms   <= i_cfg_data;
                idc_pkg::CfgGravity:
                    r_cfg.gravity_offset <= i_cfg_data[idc_pkg::GravW-1:0];
                default: ;
            endcase
        end
    end

    idc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_accel_x        (i_s_axis_tdata[15:0]),
        .i_accel_y        (i_s_axis_tdata[31:16]),
        .i_accel_z        (i_s_axis_tdata[47:32]),
        .i_stamp_ms       (i_s_axis_tdata[79:48]),
        .i_button_pressed (i_s_axis_tdata[80]),
        .i_link_connected (i_s_axis_tdata[81]),
        .i_gravity_offset (r_cfg.gravity_offset),
        .o_push           (w_push),
        .o_item           (w_front_item),
        .i_full           (w_full)
    );

    idc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    idc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_queue_valid),
        .o_pop    (w_pop),
        .i_item   (w_queue_item),
        .i_cfg    (r_cfg),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    assign o_m_axis_tdata = {4'b0000, w_result};

    `IDC_ASSERT(a_no_overflow, w_push |-> !w_full, "queue push while full")
    `IDC_ASSERT(a_end_closes, (o_m_axis_tvalid && (o_m_axis_tdata[3:2] != idc_pkg::OutcomeNone)) |-> !o_m_axis_tdata[0], "outcome with alert still on")
    `IDC_ASSERT(a_impact_opens, (o_m_axis_tvalid && o_m_axis_tdata[1] && (r_cfg.window_ms != 16'd0)) |-> o_m_axis_tdata[0], "impact did not open window")
    `IDC_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule
